[design/linear_kalman_filter_defines.svh]
// ----------------------------------------------------------------------------
// Linear Kalman filter assertion macros
// Assertion wrappers shared by the filter RTL; NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KALMAN_FILTER_DEFINES_SVH
`define LINEAR_KALMAN_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, masked while reset is held
`define LKF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also covers the reset cycles
`define LKF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKF_ASSERT(label, clk, rst_n, prop, msg)
`define LKF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[design/lkf_pkg.sv]
// ----------------------------------------------------------------------------
// lkf_pkg
// Types, codes and the update microprogram of the linear Kalman filter.
// ----------------------------------------------------------------------------
package lkf_pkg;

    // request kinds, decoded by the high bit (code three acts as an update)
    typedef enum logic [1:0] {
        REQ_INIT_GIVEN = 2'd0,
        REQ_INIT_ZERO  = 2'd1,
        REQ_UPDATE     = 2'd2
    } req_t;

    // result status
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_INIT = 2'd1,
        ST_SINGULAR = 2'd2
    } status_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_H_PACKED  = 3'd0,
        CFG_R_VAR     = 3'd1,
        CFG_Q_TOP     = 3'd2,
        CFG_Q_BOTTOM  = 3'd3,
        CFG_P0_TOP    = 3'd4,
        CFG_P0_BOTTOM = 3'd5
    } cfg_idx_t;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam logic [30:0] R_VAR_RESET = 31'd65536;

    typedef struct packed {
        logic [63:0] h_packed;
        logic [30:0] r_var;
        logic [63:0] q_top;
        logic [63:0] q_bottom;
        logic [63:0] p0_top;
        logic [63:0] p0_bottom;
    } cfg_t;

    // input item payload (request kind travels separately)
    typedef struct packed {
        logic signed [31:0] init_pos_1;
        logic signed [31:0] init_pos_0;
        logic [30:0]        start_time;
        logic [30:0]        step_time;
        logic signed [31:0] phi_11;
        logic signed [31:0] phi_10;
        logic signed [31:0] phi_01;
        logic signed [31:0] phi_00;
        logic signed [31:0] measurement;
    } in_t;

    // filter state as reported
    typedef struct packed {
        logic [31:0]        filter_time;
        logic signed [31:0] cov_11;
        logic signed [31:0] cov_10;
        logic signed [31:0] cov_01;
        logic signed [31:0] cov_00;
        logic signed [31:0] est_1;
        logic signed [31:0] est_0;
    } res_t;

    // datapath operand and destination selects
    typedef enum logic [5:0] {
        SEL_ZERO,
        SEL_X0, SEL_X1,
        SEL_P0, SEL_P1, SEL_P2, SEL_P3,
        SEL_PH0, SEL_PH1, SEL_PH2, SEL_PH3,
        SEL_Z, SEL_H0, SEL_H1,
        SEL_Q0, SEL_Q1, SEL_Q2, SEL_Q3, SEL_R,
        SEL_M0, SEL_M1, SEL_M2, SEL_M3,
        SEL_PP0, SEL_PP1, SEL_PP2, SEL_PP3,
        SEL_XP0, SEL_XP1, SEL_V0, SEL_V1, SEL_S,
        SEL_K0, SEL_K1, SEL_Y, SEL_W0, SEL_W1
    } sel_t;

    // micro-operations
    typedef enum logic [3:0] {
        OP_NOP,      // nothing
        OP_MUL,      // acc = fmul(a, b)
        OP_MAC,      // acc += fmul(a, b)
        OP_MSB,      // acc -= fmul(a, b)
        OP_LD,       // acc = a
        OP_ADD,      // acc += a
        OP_WR,       // dst = sat(acc)
        OP_CPY,      // dst = a
        OP_DIV,      // dst = round(a * 2^F / S), saturated
        OP_BR,       // jump to the singular tail when S <= 0
        OP_END_OK,   // correction done
        OP_END_SING  // prediction kept
    } op_t;

    typedef struct packed {
        op_t  op;
        sel_t a;
        sel_t b;
        sel_t dst;
    } uop_t;

    typedef struct packed {
        logic init_given;
        logic init_zero;
        logic load;
        logic time_add;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic s_nonpos;
        logic div_busy;
        logic div_done;
    } dp_sts_t;

    localparam int unsigned UPC_W    = 7;
    localparam logic [UPC_W-1:0] UPC_SING = 7'd77;

    function automatic uop_t mk(op_t op, sel_t a, sel_t b, sel_t dst);
        uop_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = dst;
        return u;
    endfunction

    localparam uop_t UOP_NOP = '{op: OP_NOP, a: SEL_ZERO, b: SEL_ZERO, dst: SEL_ZERO};

    // update microprogram
    function automatic uop_t upc_rom(logic [UPC_W-1:0] pc);
        uop_t u;
        case (pc)
            // M = Phi P
            7'd0:  u = mk(OP_MUL, SEL_PH0, SEL_P0, SEL_ZERO);
            7'd1:  u = mk(OP_MAC, SEL_PH1, SEL_P2, SEL_ZERO);
            7'd2:  u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_M0);
            7'd3:  u = mk(OP_MUL, SEL_PH0, SEL_P1, SEL_ZERO);
            7'd4:  u = mk(OP_MAC, SEL_PH1, SEL_P3, SEL_ZERO);
            7'd5:  u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_M1);
            7'd6:  u = mk(OP_MUL, SEL_PH2, SEL_P0, SEL_ZERO);
            7'd7:  u = mk(OP_MAC, SEL_PH3, SEL_P2, SEL_ZERO);
            7'd8:  u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_M2);
            7'd9:  u = mk(OP_MUL, SEL_PH2, SEL_P1, SEL_ZERO);
            7'd10: u = mk(OP_MAC, SEL_PH3, SEL_P3, SEL_ZERO);
            7'd11: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_M3);
            // P' = M Phi^T + Q
            7'd12: u = mk(OP_MUL, SEL_M0, SEL_PH0, SEL_ZERO);
            7'd13: u = mk(OP_MAC, SEL_M1, SEL_PH1, SEL_ZERO);
            7'd14: u = mk(OP_ADD, SEL_Q0, SEL_ZERO, SEL_ZERO);
            7'd15: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_PP0);
            7'd16: u = mk(OP_MUL, SEL_M0, SEL_PH2, SEL_ZERO);
            7'd17: u = mk(OP_MAC, SEL_M1, SEL_PH3, SEL_ZERO);
            7'd18: u = mk(OP_ADD, SEL_Q1, SEL_ZERO, SEL_ZERO);
            7'd19: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_PP1);
            7'd20: u = mk(OP_MUL, SEL_M2, SEL_PH0, SEL_ZERO);
            7'd21: u = mk(OP_MAC, SEL_M3, SEL_PH1, SEL_ZERO);
            7'd22: u = mk(OP_ADD, SEL_Q2, SEL_ZERO, SEL_ZERO);
            7'd23: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_PP2);
            7'd24: u = mk(OP_MUL, SEL_M2, SEL_PH2, SEL_ZERO);
            7'd25: u = mk(OP_MAC, SEL_M3, SEL_PH3, SEL_ZERO);
            7'd26: u = mk(OP_ADD, SEL_Q3, SEL_ZERO, SEL_ZERO);
            7'd27: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_PP3);
            // x' = Phi x
            7'd28: u = mk(OP_MUL, SEL_PH0, SEL_X0, SEL_ZERO);
            7'd29: u = mk(OP_MAC, SEL_PH1, SEL_X1, SEL_ZERO);
            7'd30: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_XP0);
            7'd31: u = mk(OP_MUL, SEL_PH2, SEL_X0, SEL_ZERO);
            7'd32: u = mk(OP_MAC, SEL_PH3, SEL_X1, SEL_ZERO);
            7'd33: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_XP1);
            // v = P' H^T, S = H v + R
            7'd34: u = mk(OP_MUL, SEL_PP0, SEL_H0, SEL_ZERO);
            7'd35: u = mk(OP_MAC, SEL_PP1, SEL_H1, SEL_ZERO);
            7'd36: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_V0);
            7'd37: u = mk(OP_MUL, SEL_PP2, SEL_H0, SEL_ZERO);
            7'd38: u = mk(OP_MAC, SEL_PP3, SEL_H1, SEL_ZERO);
            7'd39: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_V1);
            7'd40: u = mk(OP_MUL, SEL_H0, SEL_V0, SEL_ZERO);
            7'd41: u = mk(OP_MAC, SEL_H1, SEL_V1, SEL_ZERO);
            7'd42: u = mk(OP_ADD, SEL_R, SEL_ZERO, SEL_ZERO);
            7'd43: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_S);
            // let S land before testing it
            7'd44: u = UOP_NOP;
            7'd45: u = mk(OP_BR,  SEL_ZERO, SEL_ZERO, SEL_ZERO);
            // gain
            7'd46: u = mk(OP_DIV, SEL_V0, SEL_ZERO, SEL_K0);
            7'd47: u = mk(OP_DIV, SEL_V1, SEL_ZERO, SEL_K1);
            // y = z - H x'
            7'd48: u = mk(OP_LD,  SEL_Z, SEL_ZERO, SEL_ZERO);
            7'd49: u = mk(OP_MSB, SEL_H0, SEL_XP0, SEL_ZERO);
            7'd50: u = mk(OP_MSB, SEL_H1, SEL_XP1, SEL_ZERO);
            7'd51: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_Y);
            // x = x' + K y
            7'd52: u = mk(OP_LD,  SEL_XP0, SEL_ZERO, SEL_ZERO);
            7'd53: u = mk(OP_MAC, SEL_K0, SEL_Y, SEL_ZERO);
            7'd54: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_X0);
            7'd55: u = mk(OP_LD,  SEL_XP1, SEL_ZERO, SEL_ZERO);
            7'd56: u = mk(OP_MAC, SEL_K1, SEL_Y, SEL_ZERO);
            7'd57: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_X1);
            // w = H P'
            7'd58: u = mk(OP_MUL, SEL_H0, SEL_PP0, SEL_ZERO);
            7'd59: u = mk(OP_MAC, SEL_H1, SEL_PP2, SEL_ZERO);
            7'd60: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_W0);
            7'd61: u = mk(OP_MUL, SEL_H0, SEL_PP1, SEL_ZERO);
            7'd62: u = mk(OP_MAC, SEL_H1, SEL_PP3, SEL_ZERO);
            7'd63: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_W1);
            // P = P' - K w
            7'd64: u = mk(OP_LD,  SEL_PP0, SEL_ZERO, SEL_ZERO);
            7'd65: u = mk(OP_MSB, SEL_K0, SEL_W0, SEL_ZERO);
            7'd66: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_P0);
            7'd67: u = mk(OP_LD,  SEL_PP1, SEL_ZERO, SEL_ZERO);
            7'd68: u = mk(OP_MSB, SEL_K0, SEL_W1, SEL_ZERO);
            7'd69: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_P1);
            7'd70: u = mk(OP_LD,  SEL_PP2, SEL_ZERO, SEL_ZERO);
            7'd71: u = mk(OP_MSB, SEL_K1, SEL_W0, SEL_ZERO);
            7'd72: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_P2);
            7'd73: u = mk(OP_LD,  SEL_PP3, SEL_ZERO, SEL_ZERO);
            7'd74: u = mk(OP_MSB, SEL_K1, SEL_W1, SEL_ZERO);
            7'd75: u = mk(OP_WR,  SEL_ZERO, SEL_ZERO, SEL_P3);
            7'd76: u = mk(OP_END_OK, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            // singular innovation: keep the prediction
            7'd77: u = mk(OP_CPY, SEL_XP0, SEL_ZERO, SEL_X0);
            7'd78: u = mk(OP_CPY, SEL_XP1, SEL_ZERO, SEL_X1);
            7'd79: u = mk(OP_CPY, SEL_PP0, SEL_ZERO, SEL_P0);
            7'd80: u = mk(OP_CPY, SEL_PP1, SEL_ZERO, SEL_P1);
            7'd81: u = mk(OP_CPY, SEL_PP2, SEL_ZERO, SEL_P2);
            7'd82: u = mk(OP_CPY, SEL_PP3, SEL_ZERO, SEL_P3);
            7'd83: u = mk(OP_END_SING, SEL_ZERO, SEL_ZERO, SEL_ZERO);
            default: u = mk(OP_END_SING, SEL_ZERO, SEL_ZERO, SEL_ZERO);
        endcase
        return u;
    endfunction

endpackage

[design/linear_kalman_filter.sv]
// ----------------------------------------------------------------------------
// linear_kalman_filter
// Two-state, one-measurement Kalman filter in signed fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  update or init request
//  m_*       out  m_tvalid/m_tready  estimate, covariance, time, status
//  cfg_*     in   cfg_wr_en          H, R, Q, P0 registers
//
// Init and not-initialized requests skip the microprogram and go straight to the output register.
// An update steps through 77 microprogram entries on one shared multiplier;
// each of the two gain divisions holds the sequencer until its radix-2 loop
// of 33+FRAC_BITS steps is done. A singular innovation skips the divisions.
// One item is in work at a time; a new item is taken while the previous
// result still waits in the output register. Reset is synchronous.
// ----------------------------------------------------------------------------
`include "linear_kalman_filter_defines.svh"

module linear_kalman_filter #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wr_data,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // measurement, phi_00, phi_01, phi_10, phi_11, step_time, start_time,
    // init_pos_0, init_pos_1, zero pad
    input  logic [287:0] s_tdata,
    // req_type
    input  logic [1:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // est_0, est_1, cov_00, cov_01, cov_10, cov_11, filter_time
    output logic [223:0] m_tdata,
    // status
    output logic [1:0]   m_tuser
);

    lkf_pkg::cfg_t     cfg_reg;
    lkf_pkg::in_t      in_data;
    lkf_pkg::dp_cmd_t  cmd;
    lkf_pkg::dp_sts_t  dp_sts;
    lkf_pkg::res_t     res;
    lkf_pkg::status_t  status;
    logic              out_load, out_free;

    logic               m_tvalid_reg;
    logic [223:0]       m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.h_packed  <= '0;
            cfg_reg.r_var     <= lkf_pkg::R_VAR_RESET;
            cfg_reg.q_top     <= '0;
            cfg_reg.q_bottom  <= '0;
            cfg_reg.p0_top    <= '0;
            cfg_reg.p0_bottom <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lkf_pkg::CFG_H_PACKED:  cfg_reg.h_packed  <= cfg_wr_data;
                lkf_pkg::CFG_R_VAR:     cfg_reg.r_var     <= cfg_wr_data[30:0];
                lkf_pkg::CFG_Q_TOP:     cfg_reg.q_top     <= cfg_wr_data;
                lkf_pkg::CFG_Q_BOTTOM:  cfg_reg.q_bottom  <= cfg_wr_data;
                lkf_pkg::CFG_P0_TOP:    cfg_reg.p0_top    <= cfg_wr_data;
                lkf_pkg::CFG_P0_BOTTOM: cfg_reg.p0_bottom <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign in_data = s_tdata[285:0];

    lkf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_req   (s_tuser),
        .out_free (out_free),
        .sts      (dp_sts),
        .in_ready (s_tready),
        .out_load (out_load),
        .status   (status),
        .cmd      (cmd)
    );

    lkf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_data (in_data),
        .cmd     (cmd),
        .sts     (dp_sts),
        .res     (res)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= res;
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `LKF_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input accepted while an item is in work")
    `LKF_ASSERT(a_div_idle, aclk, aresetn, s_tready |-> !dp_sts.div_busy, "divider running while idle")
    `LKF_ASSERT(a_div_done_busy, aclk, aresetn, dp_sts.div_done |-> !s_tready, "gain finished outside an update")
    `LKF_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

[design/lkf_datapath.sv]
// ----------------------------------------------------------------------------
// lkf_datapath
// Filter state, scratch registers, one shared multiplier with accumulator
// and a radix-2 divider for the gain.
// ----------------------------------------------------------------------------
module lkf_datapath #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lkf_pkg::cfg_t     cfg,
    input  lkf_pkg::in_t      in_data,
    input  lkf_pkg::dp_cmd_t  cmd,
    output lkf_pkg::dp_sts_t  sts,
    output lkf_pkg::res_t     res
);

    localparam int unsigned ACC_W  = 67 - FRAC_BITS;
    localparam int unsigned FM_W   = 64 - FRAC_BITS;
    localparam int unsigned DW     = 33 + FRAC_BITS;
    localparam int unsigned CNT_W  = $clog2(DW + 1);
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    // architectural state
    logic signed [31:0] x_reg [2];
    logic signed [31:0] p_reg [4];
    logic [31:0]        time_reg;

    // latched item and scratch values
    lkf_pkg::in_t       in_reg;
    logic signed [31:0] m_reg [4];
    logic signed [31:0] pp_reg [4];
    logic signed [31:0] xp_reg [2];
    logic signed [31:0] v_reg [2];
    logic signed [31:0] k_reg [2];
    logic signed [31:0] w_reg [2];
    logic signed [31:0] s_reg;
    logic signed [31:0] y_reg;

    // pipeline: operand/multiply stage, then accumulate/write stage
    lkf_pkg::op_t       op1_reg;
    lkf_pkg::sel_t      dst1_reg;
    logic signed [31:0] a1_reg;
    logic signed [63:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // divider
    logic               div_busy_reg, div_done_reg, div_neg_reg;
    logic [CNT_W-1:0]   div_cnt_reg;
    logic [32:0]        div_rem_reg;
    logic [DW-1:0]      div_dnd_reg;
    lkf_pkg::sel_t      div_dst_reg;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        a_abs;
    logic signed [31:0] k_val;

    logic signed [31:0] opa, opb, sat_val, wr_val;
    logic signed [63:0] prod_rnd;
    logic signed [FM_W-1:0] fm;
    logic               wr_en;
    lkf_pkg::sel_t      wr_dst;

    function automatic logic signed [31:0] rd(lkf_pkg::sel_t s);
        logic signed [31:0] r;
        case (s)
            lkf_pkg::SEL_X0:  r = x_reg[0];
            lkf_pkg::SEL_X1:  r = x_reg[1];
            lkf_pkg::SEL_P0:  r = p_reg[0];
            lkf_pkg::SEL_P1:  r = p_reg[1];
            lkf_pkg::SEL_P2:  r = p_reg[2];
            lkf_pkg::SEL_P3:  r = p_reg[3];
            lkf_pkg::SEL_PH0: r = in_reg.phi_00;
            lkf_pkg::SEL_PH1: r = in_reg.phi_01;
            lkf_pkg::SEL_PH2: r = in_reg.phi_10;
            lkf_pkg::SEL_PH3: r = in_reg.phi_11;
            lkf_pkg::SEL_Z:   r = in_reg.measurement;
            lkf_pkg::SEL_H0:  r = cfg.h_packed[63:32];
            lkf_pkg::SEL_H1:  r = cfg.h_packed[31:0];
            lkf_pkg::SEL_Q0:  r = cfg.q_top[63:32];
            lkf_pkg::SEL_Q1:  r = cfg.q_top[31:0];
            lkf_pkg::SEL_Q2:  r = cfg.q_bottom[63:32];
            lkf_pkg::SEL_Q3:  r = cfg.q_bottom[31:0];
            lkf_pkg::SEL_R:   r = {1'b0, cfg.r_var};
            lkf_pkg::SEL_M0:  r = m_reg[0];
            lkf_pkg::SEL_M1:  r = m_reg[1];
            lkf_pkg::SEL_M2:  r = m_reg[2];
            lkf_pkg::SEL_M3:  r = m_reg[3];
            lkf_pkg::SEL_PP0: r = pp_reg[0];
            lkf_pkg::SEL_PP1: r = pp_reg[1];
            lkf_pkg::SEL_PP2: r = pp_reg[2];
            lkf_pkg::SEL_PP3: r = pp_reg[3];
            lkf_pkg::SEL_XP0: r = xp_reg[0];
            lkf_pkg::SEL_XP1: r = xp_reg[1];
            lkf_pkg::SEL_V0:  r = v_reg[0];
            lkf_pkg::SEL_V1:  r = v_reg[1];
            lkf_pkg::SEL_S:   r = s_reg;
            lkf_pkg::SEL_K0:  r = k_reg[0];
            lkf_pkg::SEL_K1:  r = k_reg[1];
            lkf_pkg::SEL_Y:   r = y_reg;
            lkf_pkg::SEL_W0:  r = w_reg[0];
            lkf_pkg::SEL_W1:  r = w_reg[1];
            default:          r = '0;
        endcase
        return r;
    endfunction

    // operand select
    assign opa = rd(cmd.uop.a);
    assign opb = rd(cmd.uop.b);

    // stage one: register operands and product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op1_reg <= lkf_pkg::OP_NOP;
        end else begin
            op1_reg <= cmd.uop.op;
        end
        dst1_reg <= cmd.uop.dst;
        a1_reg   <= opa;
        prod_reg <= opa * opb;
    end

    // rounded rescale, floor after adding half an lsb
    assign prod_rnd = prod_reg + RND;
    assign fm       = prod_rnd[63:FRAC_BITS];

    // stage two: accumulator
    always_comb begin
        acc_next = acc_reg;
        case (op1_reg)
            lkf_pkg::OP_MUL: acc_next = ACC_W'(fm);
            lkf_pkg::OP_MAC: acc_next = acc_reg + ACC_W'(fm);
            lkf_pkg::OP_MSB: acc_next = acc_reg - ACC_W'(fm);
            lkf_pkg::OP_LD:  acc_next = ACC_W'(a1_reg);
            lkf_pkg::OP_ADD: acc_next = acc_reg + ACC_W'(a1_reg);
            default:         acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // saturate accumulator to 32 bits
    always_comb begin
        if (&acc_reg[ACC_W-1:31] || ~|acc_reg[ACC_W-1:31]) begin
            sat_val = acc_reg[31:0];
        end else if (acc_reg[ACC_W-1]) begin
            sat_val = 32'sh8000_0000;
        end else begin
            sat_val = 32'sh7FFF_FFFF;
        end
    end

    // divider step and signed, saturated gain
    assign a_abs  = a1_reg[31] ? 32'(-a1_reg) : a1_reg;
    assign rem_sh = {div_rem_reg[31:0], div_dnd_reg[DW-1]};
    assign rem_ge = rem_sh >= {1'b0, s_reg};

    always_comb begin
        if (div_neg_reg) begin
            if (|div_dnd_reg[DW-1:32] || (div_dnd_reg[31] && |div_dnd_reg[30:0])) begin
                k_val = 32'sh8000_0000;
            end else begin
                k_val = -$signed(div_dnd_reg[31:0]);
            end
        end else begin
            if (|div_dnd_reg[DW-1:31]) begin
                k_val = 32'sh7FFF_FFFF;
            end else begin
                k_val = div_dnd_reg[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
        end else begin
            div_done_reg <= 1'b0;
            if (op1_reg == lkf_pkg::OP_DIV) begin
                div_busy_reg <= 1'b1;
            end else if (div_busy_reg && div_cnt_reg == CNT_W'(1)) begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
        end
        if (op1_reg == lkf_pkg::OP_DIV) begin
            div_cnt_reg <= CNT_W'(DW);
            div_rem_reg <= '0;
            div_dnd_reg <= DW'({a_abs, {FRAC_BITS{1'b0}}}) + DW'(s_reg[31:1]);
            div_neg_reg <= a1_reg[31];
            div_dst_reg <= dst1_reg;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
            div_rem_reg <= rem_ge ? rem_sh - {1'b0, s_reg} : rem_sh;
            div_dnd_reg <= {div_dnd_reg[DW-2:0], rem_ge};
        end
    end

    // write-back select
    always_comb begin
        wr_en  = 1'b0;
        wr_dst = dst1_reg;
        wr_val = sat_val;
        if (div_done_reg) begin
            wr_en  = 1'b1;
            wr_dst = div_dst_reg;
            wr_val = k_val;
        end else if (op1_reg == lkf_pkg::OP_WR) begin
            wr_en  = 1'b1;
        end else if (op1_reg == lkf_pkg::OP_CPY) begin
            wr_en  = 1'b1;
            wr_val = a1_reg;
        end
    end

    // state and scratch registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg[0] <= '0;
            x_reg[1] <= '0;
            for (int i = 0; i < 4; i++) begin
                p_reg[i] <= '0;
            end
            time_reg <= '0;
        end else if (cmd.init_given || cmd.init_zero) begin
            x_reg[0] <= cmd.init_given ? in_reg.init_pos_0 : 32'sd0;
            x_reg[1] <= cmd.init_given ? in_reg.init_pos_1 : 32'sd0;
            time_reg <= cmd.init_given ? {1'b0, in_reg.start_time} : 32'd0;
            p_reg[0] <= cfg.p0_top[63:32];
            p_reg[1] <= cfg.p0_top[31:0];
            p_reg[2] <= cfg.p0_bottom[63:32];
            p_reg[3] <= cfg.p0_bottom[31:0];
        end else begin
            if (cmd.time_add) begin
                time_reg <= time_reg + {1'b0, in_reg.step_time};
            end
            if (wr_en) begin
                case (wr_dst)
                    lkf_pkg::SEL_X0: x_reg[0] <= wr_val;
                    lkf_pkg::SEL_X1: x_reg[1] <= wr_val;
                    lkf_pkg::SEL_P0: p_reg[0] <= wr_val;
                    lkf_pkg::SEL_P1: p_reg[1] <= wr_val;
                    lkf_pkg::SEL_P2: p_reg[2] <= wr_val;
                    lkf_pkg::SEL_P3: p_reg[3] <= wr_val;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= in_data;
        end
        if (wr_en) begin
            case (wr_dst)
                lkf_pkg::SEL_M0:  m_reg[0]  <= wr_val;
                lkf_pkg::SEL_M1:  m_reg[1]  <= wr_val;
                lkf_pkg::SEL_M2:  m_reg[2]  <= wr_val;
                lkf_pkg::SEL_M3:  m_reg[3]  <= wr_val;
                lkf_pkg::SEL_PP0: pp_reg[0] <= wr_val;
                lkf_pkg::SEL_PP1: pp_reg[1] <= wr_val;
                lkf_pkg::SEL_PP2: pp_reg[2] <= wr_val;
                lkf_pkg::SEL_PP3: pp_reg[3] <= wr_val;
                lkf_pkg::SEL_XP0: xp_reg[0] <= wr_val;
                lkf_pkg::SEL_XP1: xp_reg[1] <= wr_val;
                lkf_pkg::SEL_V0:  v_reg[0]  <= wr_val;
                lkf_pkg::SEL_V1:  v_reg[1]  <= wr_val;
                lkf_pkg::SEL_S:   s_reg     <= wr_val;
                lkf_pkg::SEL_K0:  k_reg[0]  <= wr_val;
                lkf_pkg::SEL_K1:  k_reg[1]  <= wr_val;
                lkf_pkg::SEL_Y:   y_reg     <= wr_val;
                lkf_pkg::SEL_W0:  w_reg[0]  <= wr_val;
                lkf_pkg::SEL_W1:  w_reg[1]  <= wr_val;
                default: ;
            endcase
        end
    end

    // status and result
    assign sts.s_nonpos = s_reg[31] || (s_reg == 32'sd0);
    assign sts.div_busy = div_busy_reg;
    assign sts.div_done = div_done_reg;

    assign res.est_0       = x_reg[0];
    assign res.est_1       = x_reg[1];
    assign res.cov_00      = p_reg[0];
    assign res.cov_01      = p_reg[1];
    assign res.cov_10      = p_reg[2];
    assign res.cov_11      = p_reg[3];
    assign res.filter_time = time_reg;

endmodule

[design/lkf_ctrl.sv]
// ----------------------------------------------------------------------------
// lkf_ctrl
// Request decode and microprogram sequencer of the Kalman filter.
// ----------------------------------------------------------------------------
module lkf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [1:0]        in_req,
    input  logic              out_free,
    input  lkf_pkg::dp_sts_t  sts,
    output logic              in_ready,
    output logic              out_load,
    output lkf_pkg::status_t  status,
    output lkf_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_DIV_WAIT,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [lkf_pkg::UPC_W-1:0] pc_reg;
    logic [1:0]              req_reg;
    logic                    ready_flag_reg;
    lkf_pkg::status_t        status_reg;
    lkf_pkg::uop_t           uop;

    assign uop      = lkf_pkg::upc_rom(pc_reg);
    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && out_free;
    assign status   = status_reg;

    // commands to the datapath
    always_comb begin
        cmd            = '0;
        cmd.uop        = lkf_pkg::UOP_NOP;
        cmd.load       = in_ready && in_valid;
        if (state_reg == ST_DECODE) begin
            cmd.init_given = !req_reg[1] && (req_reg == lkf_pkg::REQ_INIT_GIVEN);
            cmd.init_zero  = !req_reg[1] && (req_reg == lkf_pkg::REQ_INIT_ZERO);
            cmd.time_add   = req_reg[1] && ready_flag_reg;
        end
        if (state_reg == ST_RUN) begin
            case (uop.op)
                lkf_pkg::OP_BR, lkf_pkg::OP_END_OK, lkf_pkg::OP_END_SING: ;
                default: cmd.uop = uop;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            req_reg        <= '0;
            ready_flag_reg <= 1'b0;
            status_reg     <= lkf_pkg::ST_OK;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        req_reg   <= in_req;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    pc_reg <= '0;
                    if (!req_reg[1]) begin
                        ready_flag_reg <= 1'b1;
                        status_reg     <= lkf_pkg::ST_OK;
                        state_reg      <= ST_DONE;
                    end else if (!ready_flag_reg) begin
                        status_reg <= lkf_pkg::ST_NOT_INIT;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    case (uop.op)
                        lkf_pkg::OP_BR: begin
                            pc_reg <= sts.s_nonpos ? lkf_pkg::UPC_SING : pc_reg + 1'b1;
                        end
                        lkf_pkg::OP_DIV: begin
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= ST_DIV_WAIT;
                        end
                        lkf_pkg::OP_END_OK: begin
                            status_reg <= lkf_pkg::ST_OK;
                            state_reg  <= ST_FLUSH;
                        end
                        lkf_pkg::OP_END_SING: begin
                            status_reg <= lkf_pkg::ST_SINGULAR;
                            state_reg  <= ST_FLUSH;
                        end
                        default: pc_reg <= pc_reg + 1'b1;
                    endcase
                end
                ST_DIV_WAIT: begin
                    if (sts.div_done) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_FLUSH: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[sim/linear_kalman_filter_test.sv]
// ----------------------------------------------------------------------------
// linear_kalman_filter_test
// Self-checking bench for the two-state Kalman filter: a bit-exact predictor
// tracks the filter state per item, random idling on both stream sides, one
// long output stall, several register settings including the extremes.
// ----------------------------------------------------------------------------
module linear_kalman_filter_test;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [63:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;
    logic [1:0]   m_tuser;

    linear_kalman_filter dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    localparam int FB = 16;

    // register copy and filter state of the predictor
    logic [63:0]   h_reg, q_t, q_b, p0_t, p0_b;
    logic [30:0]   r_reg;
    longint        est[2], cov[4];
    logic [31:0]   ftime;
    bit            primed;

    typedef struct {
        lkf_pkg::res_t    res;
        lkf_pkg::status_t st;
    } expect_t;
    expect_t filter_out_q[$];

    int  errors = 0, n_items = 0, n_results = 0, n_sing = 0, n_noinit = 0;
    int  stall_hold = 0;
    bit  stim_done = 0;

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // product rescaled with round half up (arithmetic shift floors)
    function automatic longint fmul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FB - 1));
        return p >>> FB;
    endfunction

    function automatic expect_t snapshot(lkf_pkg::status_t st);
        expect_t e;
        e.res.est_0 = 32'(est[0]);
        e.res.est_1 = 32'(est[1]);
        e.res.cov_00 = 32'(cov[0]);
        e.res.cov_01 = 32'(cov[1]);
        e.res.cov_10 = 32'(cov[2]);
        e.res.cov_11 = 32'(cov[3]);
        e.res.filter_time = ftime;
        e.st = st;
        return e;
    endfunction

    // one request through the filter equations
    function automatic expect_t filter_step(logic [1:0] kind, lkf_pkg::in_t d);
        longint ph[4], m[4], pp[4], q[4], xp[2], v[2], k[2], w[2];
        longint h0, h1, s, y, num, a, qq;
        if (!kind[1]) begin
            if (kind == lkf_pkg::REQ_INIT_GIVEN) begin
                est[0] = d.init_pos_0;
                est[1] = d.init_pos_1;
                ftime = {1'b0, d.start_time};
            end else begin
                est[0] = 0;
                est[1] = 0;
                ftime = '0;
            end
            cov[0] = sx(p0_t[63:32]); cov[1] = sx(p0_t[31:0]);
            cov[2] = sx(p0_b[63:32]); cov[3] = sx(p0_b[31:0]);
            primed = 1;
            return snapshot(lkf_pkg::ST_OK);
        end
        if (!primed) return snapshot(lkf_pkg::ST_NOT_INIT);
        ph[0] = d.phi_00; ph[1] = d.phi_01; ph[2] = d.phi_10; ph[3] = d.phi_11;
        q[0] = sx(q_t[63:32]); q[1] = sx(q_t[31:0]);
        q[2] = sx(q_b[63:32]); q[3] = sx(q_b[31:0]);
        h0 = sx(h_reg[63:32]); h1 = sx(h_reg[31:0]);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                m[i*2+j] = sat(fmul(ph[i*2], cov[j]) + fmul(ph[i*2+1], cov[2+j]));
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                pp[i*2+j] = sat(fmul(m[i*2], ph[j*2]) + fmul(m[i*2+1], ph[j*2+1])
                                + q[i*2+j]);
        for (int i = 0; i < 2; i++)
            xp[i] = sat(fmul(ph[i*2], est[0]) + fmul(ph[i*2+1], est[1]));
        ftime = ftime + {1'b0, d.step_time};
        est = xp;
        cov = pp;
        for (int i = 0; i < 2; i++)
            v[i] = sat(fmul(pp[i*2], h0) + fmul(pp[i*2+1], h1));
        s = sat(fmul(h0, v[0]) + fmul(h1, v[1]) + longint'(r_reg));
        if (s <= 0) return snapshot(lkf_pkg::ST_SINGULAR);
        // gain, rounded with ties away from zero
        for (int i = 0; i < 2; i++) begin
            num = v[i] * (64'sd1 <<< FB);
            a = num < 0 ? -num : num;
            qq = (a + s / 2) / s;
            k[i] = sat(num < 0 ? -qq : qq);
        end
        y = sat(longint'(d.measurement) - (fmul(h0, xp[0]) + fmul(h1, xp[1])));
        for (int i = 0; i < 2; i++) est[i] = sat(xp[i] + fmul(k[i], y));
        for (int j = 0; j < 2; j++) w[j] = sat(fmul(h0, pp[j]) + fmul(h1, pp[2+j]));
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                cov[i*2+j] = sat(pp[i*2+j] - fmul(k[i], w[j]));
        return snapshot(lkf_pkg::ST_OK);
    endfunction

    task automatic write_reg(lkf_pkg::cfg_idx_t idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            lkf_pkg::CFG_H_PACKED:  h_reg = val;
            lkf_pkg::CFG_R_VAR:     r_reg = val[30:0];
            lkf_pkg::CFG_Q_TOP:     q_t = val;
            lkf_pkg::CFG_Q_BOTTOM:  q_b = val;
            lkf_pkg::CFG_P0_TOP:    p0_t = val;
            default:                p0_b = val;
        endcase
    endtask

    task automatic set_filter(logic [63:0] h, logic [30:0] r, logic [63:0] qt,
                              logic [63:0] qb, logic [63:0] pt, logic [63:0] pb);
        write_reg(lkf_pkg::CFG_H_PACKED, h);
        write_reg(lkf_pkg::CFG_R_VAR, {33'd0, r});
        write_reg(lkf_pkg::CFG_Q_TOP, qt);
        write_reg(lkf_pkg::CFG_Q_BOTTOM, qb);
        write_reg(lkf_pkg::CFG_P0_TOP, pt);
        write_reg(lkf_pkg::CFG_P0_BOTTOM, pb);
    endtask

    // send one item after a random gap (none with no_gap); predictor runs at acceptance
    task automatic send_item(logic [1:0] kind, lkf_pkg::in_t d, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{288 - $bits(lkf_pkg::in_t){1'b0}}, d};
        s_tuser <= kind;
        do @(posedge aclk); while (!s_tready);
        filter_out_q.push_back(filter_step(kind, d));
        n_items++;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (filter_out_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (250) @(posedge aclk);
    endtask

    // moderate magnitudes keep the filter away from constant saturation
    function automatic logic [31:0] rnd_q(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic lkf_pkg::in_t rnd_item(bit wide);
        lkf_pkg::in_t d;
        d = 286'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom});
        if (!wide) begin
            d.phi_00 = 32'sh10000 + rnd_q(8192);
            d.phi_01 = rnd_q(32768);
            d.phi_10 = rnd_q(8192);
            d.phi_11 = 32'sh10000 + rnd_q(8192);
            d.measurement = rnd_q(1 << 22);
            d.init_pos_0 = rnd_q(1 << 22);
            d.init_pos_1 = rnd_q(1 << 20);
        end
        return d;
    endfunction

    function automatic logic [1:0] rnd_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return lkf_pkg::REQ_INIT_GIVEN;
        if (r == 1) return lkf_pkg::REQ_INIT_ZERO;
        if (r == 2) return 2'd3;
        return lkf_pkg::REQ_UPDATE;
    endfunction

    task automatic test_directed;
        lkf_pkg::in_t d;
        // update before any init
        d = rnd_item(0);
        send_item(lkf_pkg::REQ_UPDATE, d);
        send_item(2'd3, d);
        drain();
        set_filter({32'sh10000, 32'sh0}, 31'd65536, {32'sh100, 32'sh0},
                   {32'sh0, 32'sh100}, {32'sh40000, 32'sh0}, {32'sh0, 32'sh40000});
        send_item(lkf_pkg::REQ_INIT_ZERO, d);
        send_item(lkf_pkg::REQ_UPDATE, d);
        d.start_time = '1;
        d.init_pos_0 = 32'sh7fffffff;
        d.init_pos_1 = 32'sh80000000;
        send_item(lkf_pkg::REQ_INIT_GIVEN, d);
        d.step_time = '1;
        send_item(lkf_pkg::REQ_UPDATE, d);
        send_item(lkf_pkg::REQ_UPDATE, d);
        d = '1;
        send_item(lkf_pkg::REQ_UPDATE, d);
        d = '0;
        send_item(lkf_pkg::REQ_UPDATE, d);
        d.phi_00 = 32'sh80000000; d.phi_01 = 32'sh7fffffff;
        d.phi_10 = 32'sh7fffffff; d.phi_11 = 32'sh80000000;
        d.measurement = 32'sh80000000;
        send_item(lkf_pkg::REQ_UPDATE, d);
        send_item(lkf_pkg::REQ_INIT_ZERO, d);
        drain();
        // singular innovation: zero H and zero R
        set_filter(64'd0, 31'd0, 64'd0, 64'd0, '1, {32'sh7fffffff, 32'sh80000000});
        d = rnd_item(0);
        send_item(lkf_pkg::REQ_INIT_GIVEN, d);
        send_item(lkf_pkg::REQ_UPDATE, d);
        drain();
        // negative S from a negative covariance
        write_reg(lkf_pkg::CFG_H_PACKED, {32'sh10000, 32'sh10000});
        write_reg(lkf_pkg::CFG_P0_TOP, {32'shffff0000, 32'sh0});
        send_item(lkf_pkg::REQ_INIT_ZERO, d);
        send_item(lkf_pkg::REQ_UPDATE, d);
        drain();
        // extremes of every register
        set_filter('1, 31'h7fffffff, '1, {32'sh7fffffff, 32'sh80000000},
                   {32'sh7fffffff, 32'sh7fffffff}, {32'sh80000000, 32'sh80000000});
        d = '1;
        send_item(lkf_pkg::REQ_INIT_GIVEN, d);
        send_item(lkf_pkg::REQ_UPDATE, d);
        d = rnd_item(1);
        send_item(lkf_pkg::REQ_UPDATE, d);
        drain();
    endtask

    task automatic random_phase(int count, bit wide);
        for (int i = 0; i < count; i++)
            send_item(i == 0 ? lkf_pkg::REQ_INIT_GIVEN : rnd_kind(), rnd_item(wide));
        drain();
    endtask

    task automatic test_random;
        set_filter({32'sh10000, 32'sh0}, 31'd65536, {32'sh400, 32'sh0},
                   {32'sh0, 32'sh400}, {32'sh100000, 32'sh0}, {32'sh0, 32'sh100000});
        random_phase(400, 0);
        set_filter({32'sh8000, 32'sh4000}, 31'd4096, {32'sh1000, 32'sh100},
                   {32'sh100, 32'sh1000}, {32'sh20000, 32'sh8000},
                   {32'sh8000, 32'sh20000});
        random_phase(400, 0);
        set_filter({$urandom, $urandom}, 31'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(300, 1);
    endtask

    // receiver stalls for a long stretch while items keep coming
    task automatic test_backpressure;
        stall_hold = 2000;
        for (int i = 0; i < 6; i++)
            send_item(i == 0 ? lkf_pkg::REQ_INIT_ZERO : lkf_pkg::REQ_UPDATE,
                      rnd_item(0), 1);
        drain();
    endtask

    // output ready: random waits per item plus the long hold
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            if (stall_hold > 0) begin
                m_tready <= 1'b0;
                repeat (stall_hold) @(posedge aclk);
                stall_hold = 0;
            end
            w = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready) && stall_hold == 0);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        expect_t e;
        lkf_pkg::res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            n_results++;
            if (filter_out_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h status %0d", got, m_tuser);
            end else begin
                e = filter_out_q.pop_front();
                if (e.st == lkf_pkg::ST_SINGULAR) n_sing++;
                if (e.st == lkf_pkg::ST_NOT_INIT) n_noinit++;
                if (got !== e.res || m_tuser !== e.st) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at result %0d:", n_results);
                        $display("  exp est %h %h cov %h %h %h %h t %h st %0d",
                                 e.res.est_0, e.res.est_1, e.res.cov_00, e.res.cov_01,
                                 e.res.cov_10, e.res.cov_11, e.res.filter_time, e.st);
                        $display("  got est %h %h cov %h %h %h %h t %h st %0d",
                                 got.est_0, got.est_1, got.cov_00, got.cov_01,
                                 got.cov_10, got.cov_11, got.filter_time, m_tuser);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en ||
                stim_done)
                idle = 0;
            else
                idle++;
            if (idle >= 20000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        h_reg = '0; r_reg = lkf_pkg::R_VAR_RESET; q_t = '0; q_b = '0;
        p0_t = '0; p0_b = '0;
        est[0] = 0; est[1] = 0; cov = '{0, 0, 0, 0}; ftime = '0; primed = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random();
        stim_done = 1;
        errors += filter_out_q.size();
        $display("%0d items sent, %0d results checked (%0d singular, %0d before init)",
                 n_items, n_results, n_sing, n_noinit);
        $display("covered init kinds, updates, request code three, long output stall");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
